>>> rtl/core/vabp_pkg.sv
`default_nettype none
package vabp_pkg;

  // file header length and its counter width
  localparam int unsigned HeaderBytes = 26;
  localparam int unsigned HdrCntW     = 5;

  // block codes
  localparam logic [7:0] CodeSound   = 8'h01;
  localparam logic [7:0] CodeSilence = 8'h03;
  localparam logic [7:0] CodeLoopBeg = 8'h06;
  localparam logic [7:0] CodeLoopEnd = 8'h07;
  localparam logic [7:0] CodeTyped   = 8'h09;

  // time constants with fixed rates
  localparam logic [7:0] Tc11kA = 8'ha5;
  localparam logic [7:0] Tc11kB = 8'ha6;
  localparam logic [7:0] Tc22kA = 8'hd2;
  localparam logic [7:0] Tc22kB = 8'hd3;
  localparam logic [31:0] Rate11k = 32'd11025;
  localparam logic [31:0] Rate22k = 32'd22050;

  // rate divider: 1000000 / (256 - tc)
  localparam int unsigned DivQW    = 20;
  localparam int unsigned DivRW    = 9;
  localparam int unsigned DivSteps = DivQW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);
  localparam logic [DivQW-1:0] DivDividend = 20'd1000000;
  localparam logic [DivRW-1:0] DivBase     = 9'd256;

  // input queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_end;
  } item_t;

  typedef struct packed {
    logic       valid;
    item_t      item;
  } front_out_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sample;
    logic [31:0] sample_rate;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/vabp_front.sv
`default_nettype none
module vabp_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  vabp_pkg::item_t      item_i,
  output vabp_pkg::front_out_t front_o,
  input  wire                  take_i
);

  vabp_pkg::item_t                 mem_q [vabp_pkg::QDepth];
  logic [vabp_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [vabp_pkg::QCntW-1:0]      cnt_q;
  logic                            do_push, do_pop;

  assign full    = (cnt_q == vabp_pkg::QCntW'(vabp_pkg::QDepth));
  assign do_push = push && !full;
  assign do_pop  = take_i && (cnt_q != '0);

  assign front_o.valid = (cnt_q != '0);
  assign front_o.item  = mem_q[rd_ptr_q];

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == vabp_pkg::QPtrW'(vabp_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == vabp_pkg::QPtrW'(vabp_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/vabp_rate_div.sv
`default_nettype none
module vabp_rate_div (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  input  wire  [vabp_pkg::DivRW-1:0]      divisor_i,
  output logic                            busy_o,
  output logic [vabp_pkg::DivQW-1:0]      quotient_o
);

  logic [vabp_pkg::DivCntW-1:0] cnt_q;
  logic [vabp_pkg::DivRW-1:0]   den_q, rem_q;
  logic [vabp_pkg::DivQW-1:0]   quot_q;
  logic [vabp_pkg::DivRW:0]     shifted, diff;
  logic                         fits;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quot_q;

  // one restoring step per cycle
  assign shifted = {rem_q, quot_q[vabp_pkg::DivQW-1]};
  assign fits    = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= vabp_pkg::DivCntW'(vabp_pkg::DivSteps);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= vabp_pkg::DivDividend;
    end else if (busy_o) begin
      rem_q  <= fits ? diff[vabp_pkg::DivRW-1:0] : shifted[vabp_pkg::DivRW-1:0];
      quot_q <= {quot_q[vabp_pkg::DivQW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/vabp_back.sv
`default_nettype none
module vabp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  vabp_pkg::front_out_t front_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  output vabp_pkg::result_t    out_o,
  input  wire                  pop
);

  // parse phases
  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhCode   = 4'd1;
  localparam logic [3:0] PhLen0   = 4'd2;
  localparam logic [3:0] PhLen1   = 4'd3;
  localparam logic [3:0] PhLen2   = 4'd4;
  localparam logic [3:0] PhFields = 4'd5;
  localparam logic [3:0] PhData   = 4'd6;
  localparam logic [3:0] PhSkip   = 4'd7;
  localparam logic [3:0] PhDone   = 4'd8;

  logic [3:0]                   phase_q, phase_d;
  logic [vabp_pkg::HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d, hdr_inc;
  logic [7:0]                   code_q, code_d;
  logic [3:0]                   fi_q, fi_d;
  logic [23:0]                  left_q, left_d, left_dec, len_full;
  logic [31:0]                  accum_q, accum_d;
  logic [31:0]                  rate_q, rate_d;
  logic [7:0]                   depth_q, depth_d;
  logic [7:0]                   chans_q, chans_d;
  logic [15:0]                  pack_q, pack_d;
  logic                         wait_q, wait_d;
  logic                         out_valid_q;
  vabp_pkg::result_t            res_q, res_d;
  logic                         load_out, consume, div_start, div_busy;
  logic [7:0]                   b;
  logic [vabp_pkg::DivQW-1:0]   quot;
  logic [vabp_pkg::DivRW-1:0]   divisor;

  assign b        = front_i.item.data_byte;
  assign consume  = front_i.valid && !wait_q && (!out_valid_q || pop);
  assign take_o   = consume;
  assign left_dec = left_q - 24'd1;
  assign len_full = left_q | {b, 16'h0000};
  assign hdr_inc  = hdr_cnt_q + 1'b1;
  assign divisor  = vabp_pkg::DivBase - {1'b0, b};

  vabp_rate_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // parser next state
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    code_d    = code_q;
    fi_d      = fi_q;
    left_d    = left_q;
    accum_d   = accum_q;
    rate_d    = rate_q;
    depth_d   = depth_q;
    chans_d   = chans_q;
    pack_d    = pack_q;
    wait_d    = wait_q;
    load_out  = 1'b0;
    div_start = 1'b0;
    res_d     = '{kind: 1'b0, sample: b, sample_rate: rate_q};

    // divided rate comes back
    if (wait_q && !div_busy) begin
      rate_d = {{(32 - vabp_pkg::DivQW){1'b0}}, quot};
      wait_d = 1'b0;
    end

    if (consume) begin
      case (phase_q)
        PhCode: begin
          code_d = b;
          if (b == vabp_pkg::CodeSound || b == vabp_pkg::CodeTyped ||
              b == vabp_pkg::CodeSilence || b == vabp_pkg::CodeLoopBeg ||
              b == vabp_pkg::CodeLoopEnd) begin
            phase_d = PhLen0;
          end else begin
            load_out = 1'b1;
            res_d    = '{kind: 1'b1, sample: 8'h00, sample_rate: rate_q};
            phase_d  = PhDone;
          end
        end
        PhLen0: begin
          left_d  = {16'h0000, b};
          phase_d = PhLen1;
        end
        PhLen1: begin
          left_d  = left_q | {8'h00, b, 8'h00};
          phase_d = PhLen2;
        end
        PhLen2: begin
          left_d = len_full;
          if (len_full == '0) begin
            phase_d = PhCode;
          end else if (code_q == vabp_pkg::CodeSound || code_q == vabp_pkg::CodeTyped) begin
            fi_d    = '0;
            accum_d = '0;
            phase_d = PhFields;
          end else begin
            phase_d = PhSkip;
          end
        end
        PhFields: begin
          left_d = left_dec;
          fi_d   = fi_q + 1'b1;
          if (code_q == vabp_pkg::CodeSound) begin
            if (fi_q == 4'd0) begin
              if (b == vabp_pkg::Tc11kA || b == vabp_pkg::Tc11kB) begin
                rate_d = vabp_pkg::Rate11k;
              end else if (b == vabp_pkg::Tc22kA || b == vabp_pkg::Tc22kB) begin
                rate_d = vabp_pkg::Rate22k;
              end else if (!front_i.item.file_end) begin
                div_start = 1'b1;
                wait_d    = 1'b1;
              end
            end else begin
              pack_d  = {8'h00, b};
              phase_d = (b == 8'h00) ? PhData : PhSkip;
            end
          end else if (code_q == vabp_pkg::CodeTyped) begin
            if (fi_q < 4'd4) begin
              accum_d = accum_q | ({24'h000000, b} << {fi_q[1:0], 3'b000});
              if (fi_q == 4'd3) begin
                rate_d = accum_d;
              end
            end else if (fi_q == 4'd4) begin
              depth_d = b;
            end else if (fi_q == 4'd5) begin
              chans_d = b;
            end else if (fi_q == 4'd6) begin
              pack_d = {8'h00, b};
            end else if (fi_q == 4'd7) begin
              pack_d = {b, pack_q[7:0]};
            end else if (fi_q >= 4'd11) begin
              phase_d = (depth_q == 8'd8 && chans_q == 8'd1 && pack_q == 16'h0000) ?
                        PhData : PhSkip;
            end
          end else begin
            phase_d = PhSkip;
          end
          if (left_dec == '0) begin
            phase_d = PhCode;
          end
        end
        PhData: begin
          load_out = 1'b1;
          left_d   = left_dec;
          if (left_dec == '0) begin
            phase_d = PhCode;
          end
        end
        PhSkip: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PhCode;
          end
        end
        PhDone: begin
        end
        default: begin
          if (hdr_inc >= vabp_pkg::HdrCntW'(vabp_pkg::HeaderBytes)) begin
            hdr_cnt_d = '0;
            phase_d   = PhCode;
          end else begin
            hdr_cnt_d = hdr_inc;
          end
        end
      endcase

      // last byte of the file returns the parser state to reset
      if (front_i.item.file_end) begin
        phase_d   = PhHeader;
        hdr_cnt_d = '0;
        code_d    = '0;
        fi_d      = '0;
        left_d    = '0;
        accum_d   = '0;
        rate_d    = '0;
        depth_d   = '0;
        chans_d   = '0;
        pack_d    = '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= '0;
      code_q    <= '0;
      fi_q      <= '0;
      left_q    <= '0;
      accum_q   <= '0;
      rate_q    <= '0;
      depth_q   <= '0;
      chans_q   <= '0;
      pack_q    <= '0;
      wait_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      code_q    <= code_d;
      fi_q      <= fi_d;
      left_q    <= left_d;
      accum_q   <= accum_d;
      rate_q    <= rate_d;
      depth_q   <= depth_d;
      chans_q   <= chans_d;
      pack_q    <= pack_d;
      wait_q    <= wait_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

`ifndef SYNTHESIS
  // a started division is waited for with the divider running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (wait_q && div_busy))
    else $error("rate division not tracked");

  // finished division lands in the current rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_q && !div_busy) |=> (rate_q == {{(32 - vabp_pkg::DivQW){1'b0}}, $past(quot)}))
    else $error("divided rate not loaded");

  // skipped bytes leave the result slot empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (phase_q == PhSkip || phase_q == PhHeader)) |=> !out_valid_q)
    else $error("result made from a skipped byte");

  // no byte taken while a rate is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_q && div_busy) |-> !take_o)
    else $error("byte taken during rate division");
`endif

endmodule
`default_nettype wire

>>> rtl/core/voc_audio_block_parser_core.sv
// path: a pushed item reaches the parser in the cycle after the push; a sample
//   or end result is registered before it shows on the result ports (empty low)
// throughput: 1 byte per cycle while the result slot is free or popped; a type 1
//   time constant without a fixed rate stalls for the serial divider's 20 steps
// reset: rst_ni clears queue, parser and result register; no clearing pass
`default_nettype none
module voc_audio_block_parser_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte_i,
  input  wire         file_end_i,
  output logic        empty,
  input  wire         pop,
  output logic        kind_o,
  output logic [7:0]  sample_o,
  output logic [31:0] sample_rate_o
);

  vabp_pkg::item_t      in_item;
  vabp_pkg::front_out_t front;
  vabp_pkg::result_t    res;
  logic                 take, out_valid;

  assign in_item = '{data_byte: data_byte_i, file_end: file_end_i};

  // input queue
  vabp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (in_item),
    .front_o (front),
    .take_i  (take)
  );

  // block parser and result register
  vabp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .take_o      (take),
    .out_valid_o (out_valid),
    .out_o       (res),
    .pop         (pop && !empty)
  );

  assign empty         = !out_valid;
  assign kind_o        = res.kind;
  assign sample_o      = res.sample;
  assign sample_rate_o = res.sample_rate;

endmodule
`default_nettype wire
